// ===== design/mcf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcf_pkg: shared types and constants for the min-cost flow block
// Widths, node limits, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package mcf_pkg;

   localparam int MAX_NODES = 64;
   localparam int NODE_W    = 6;
   localparam int CNT_W     = 7;                 // holds 0..MAX_NODES
   localparam int PAIR_W    = 2 * NODE_W;
   localparam int PAIRS     = MAX_NODES * MAX_NODES;
   localparam int CAP_W     = 17;                // pair sum can exceed 16 bits
   localparam int ECOST_W   = 17;                // holds the negated -32768
   localparam int DIST_W    = 24;
   localparam int ACC_W     = 40;
   localparam int FLOW_W    = 16;
   localparam int POPS_W    = 13;                // up to MAX_NODES squared

   localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
   localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0]  COST_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0]  COST_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [1:0] {
      CSR_NODE_COUNT  = 2'd0,
      CSR_SOURCE_NODE = 2'd1,
      CSR_SINK_NODE   = 2'd2,
      CSR_FLOW_DEMAND = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_RANGE,
      ST_LOOP,
      ST_SEARCH,
      ST_POP,
      ST_POP_NODE,
      ST_POP_DIST,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_WALK,
      ST_WALK_PAR,
      ST_WALK_CAP,
      ST_AUG,
      ST_AUG_PAR,
      ST_AUG_FWD,
      ST_AUG_BWD,
      ST_FIN_RD,
      ST_FIN_MUL,
      ST_FIN_ADD,
      ST_DONE
   } state_type;

endpackage

// ===== design/mcf_req_if.sv =====
// ----------------------------------------------------------------------------
// mcf_req_if / mcf_rsp_if: edge and result channels
// Valid/ready channels carrying one edge or one solve result.
// ----------------------------------------------------------------------------
interface mcf_req_if import mcf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [NODE_W-1:0]        edge_from;
   logic [NODE_W-1:0]        edge_to;
   logic [FLOW_W-1:0]        edge_capacity;
   logic signed [FLOW_W-1:0] edge_cost;
   logic                     last_edge;

   modport source(output valid, edge_from, edge_to, edge_capacity, edge_cost,
                  last_edge, input ready);
   modport sink(input valid, edge_from, edge_to, edge_capacity, edge_cost,
                last_edge, output ready);
endinterface

interface mcf_rsp_if import mcf_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    demand_met;
   logic [FLOW_W-1:0]       flow_sent;
   logic signed [ACC_W-1:0] total_cost;

   modport source(output valid, demand_met, flow_sent, total_cost, input ready);
   modport sink(input valid, demand_met, flow_sent, total_cost, output ready);
endinterface

// ===== design/min_cost_flow_spfa.sv =====
// ----------------------------------------------------------------------------
// min_cost_flow_spfa: min-cost flow by successive shortest paths
// Loads a graph one edge per transaction, then solves with queue-based
// Bellman-Ford path search and reports demand met, flow and total cost.
// ----------------------------------------------------------------------------
// Edges load at one transaction per cycle while idle. The transaction flagged
// last_edge starts the solve and the block holds req ready low until it is
// finished. Each path search makes at most n*n queue pops; each pop reads the
// node and its distance, then scans every node with a read and an evaluate
// step through the capacity, cost and distance memories, one read port each.
// Each augmentation walks the path twice, for the bottleneck and then for the
// capacity updates, then multiplies and accumulates the cost. After reset and
// after every result the capacity matrix is swept to zero, one entry per cycle,
// with req ready low; csr writes are taken at any time.
// The result sits in an output register, so the clear sweep runs while it
// waits to be taken.
module min_cost_flow_spfa import mcf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mcf_req_if.sink               req_bus,
   mcf_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [FLOW_W-1:0]     csr_wdata
);

   // ------------------------------------------------------------------------
   // Memories: residual capacity per ordered pair, edge cost per unordered
   // pair (oriented low index to high index), per-node distance and parent,
   // and the circular work queue.
   // ------------------------------------------------------------------------
   logic [CAP_W-1:0]         cap_mem  [PAIRS];
   logic signed [ECOST_W-1:0] cost_mem [PAIRS];
   logic signed [DIST_W-1:0] dist_mem [MAX_NODES];
   logic [NODE_W-1:0]        par_mem  [MAX_NODES];
   logic [NODE_W-1:0]        q_mem    [MAX_NODES];

   logic                     cap_we, cost_we, dist_we, par_we, q_we;
   logic [PAIR_W-1:0]        cap_wa, cap_ra, cost_wa, cost_ra;
   logic [CAP_W-1:0]         cap_wd;
   logic signed [ECOST_W-1:0] cost_wd;
   logic [NODE_W-1:0]        dist_wa, dist_ra, par_wa, par_ra, q_wa, q_ra;
   logic signed [DIST_W-1:0] dist_wd;
   logic [NODE_W-1:0]        par_wd, q_wd;

   logic [CAP_W-1:0]         cap_rd_ff;
   logic signed [ECOST_W-1:0] cost_rd_ff;
   logic signed [DIST_W-1:0] dist_rd_ff;
   logic [NODE_W-1:0]        par_rd_ff, q_rd_ff;

   always_ff @(posedge clock) begin
      if (cap_we) cap_mem[cap_wa] <= cap_wd;
      cap_rd_ff <= cap_mem[cap_ra];
   end

   always_ff @(posedge clock) begin
      if (cost_we) cost_mem[cost_wa] <= cost_wd;
      cost_rd_ff <= cost_mem[cost_ra];
   end

   always_ff @(posedge clock) begin
      if (dist_we) dist_mem[dist_wa] <= dist_wd;
      dist_rd_ff <= dist_mem[dist_ra];
   end

   always_ff @(posedge clock) begin
      if (par_we) par_mem[par_wa] <= par_wd;
      par_rd_ff <= par_mem[par_ra];
   end

   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_wa] <= q_wd;
      q_rd_ff <= q_mem[q_ra];
   end

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [CNT_W-1:0]  cfg_n_ff;
   logic [NODE_W-1:0] cfg_s_ff, cfg_t_ff;
   logic [FLOW_W-1:0] cfg_k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_n_ff <= CNT_W'(MAX_NODES);
         cfg_s_ff <= '0;
         cfg_t_ff <= NODE_W'(1);
         cfg_k_ff <= FLOW_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NODE_COUNT:  cfg_n_ff <= csr_wdata[CNT_W-1:0];
            CSR_SOURCE_NODE: cfg_s_ff <= csr_wdata[NODE_W-1:0];
            CSR_SINK_NODE:   cfg_t_ff <= csr_wdata[NODE_W-1:0];
            CSR_FLOW_DEMAND: cfg_k_ff <= csr_wdata;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer registers
   // ------------------------------------------------------------------------
   state_type                state_ff, state_in;
   logic [PAIR_W-1:0]        clr_ff, clr_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [POPS_W-1:0]        nn_ff, nn_in;
   logic [POPS_W-1:0]        pops_ff, pops_in;
   logic [FLOW_W-1:0]        flow_ff, flow_in;
   logic signed [ACC_W-1:0]  cost_ff, cost_in;
   logic signed [ACC_W-1:0]  prod_ff, prod_in;
   logic [FLOW_W-1:0]        f_ff, f_in;
   logic [NODE_W-1:0]        u_ff, u_in;
   logic signed [DIST_W-1:0] du_ff, du_in;
   logic [CNT_W-1:0]         v_ff, v_in;
   logic                     neg_ff, neg_in;
   logic [NODE_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [NODE_W-1:0]        cur_ff, cur_in;
   logic [NODE_W-1:0]        p_ff, p_in;
   logic [CNT_W-1:0]         steps_ff, steps_in;
   logic [MAX_NODES-1:0]     reached_ff, reached_in;
   logic [MAX_NODES-1:0]     inq_ff, inq_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_met_ff, rsp_met_in;
   logic [FLOW_W-1:0]        rsp_flow_ff, rsp_flow_in;
   logic signed [ACC_W-1:0]  rsp_cost_ff, rsp_cost_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         reached_ff   <= '0;
         inq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         reached_ff   <= reached_in;
         inq_ff       <= inq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      nn_ff       <= nn_in;
      pops_ff     <= pops_in;
      flow_ff     <= flow_in;
      cost_ff     <= cost_in;
      prod_ff     <= prod_in;
      f_ff        <= f_in;
      u_ff        <= u_in;
      du_ff       <= du_in;
      v_ff        <= v_in;
      neg_ff      <= neg_in;
      head_ff     <= head_in;
      count_ff    <= count_in;
      cur_ff      <= cur_in;
      p_ff        <= p_in;
      steps_ff    <= steps_in;
      rsp_met_ff  <= rsp_met_in;
      rsp_flow_ff <= rsp_flow_in;
      rsp_cost_ff <= rsp_cost_in;
   end

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.demand_met = rsp_met_ff;
   assign rsp_bus.flow_sent  = rsp_flow_ff;
   assign rsp_bus.total_cost = rsp_cost_ff;

   // relaxation arithmetic (only meaningful in ST_SCAN_EV), cost sum and edge order
   logic signed [ECOST_W-1:0] ecost;
   logic signed [DIST_W:0]    nd_wide;
   logic signed [DIST_W-1:0]  nd;
   logic signed [ACC_W:0]     acc_sum;
   logic [NODE_W-1:0]         vi;
   logic [NODE_W-1:0]         e_lo, e_hi;

   always_comb begin
      vi      = v_ff[NODE_W-1:0];
      ecost   = neg_ff ? -cost_rd_ff : cost_rd_ff;
      nd_wide = (DIST_W+1)'(du_ff) + (DIST_W+1)'(ecost);
      if (nd_wide > (DIST_W+1)'(DIST_MAX))      nd = DIST_MAX;
      else if (nd_wide < (DIST_W+1)'(DIST_MIN)) nd = DIST_MIN;
      else                                       nd = nd_wide[DIST_W-1:0];
      acc_sum = (ACC_W+1)'(cost_ff) + (ACC_W+1)'(prod_ff);
      e_lo = (req_bus.edge_from < req_bus.edge_to) ? req_bus.edge_from : req_bus.edge_to;
      e_hi = (req_bus.edge_from < req_bus.edge_to) ? req_bus.edge_to : req_bus.edge_from;
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      n_in        = n_ff;
      nn_in       = nn_ff;
      pops_in     = pops_ff;
      flow_in     = flow_ff;
      cost_in     = cost_ff;
      prod_in     = prod_ff;
      f_in        = f_ff;
      u_in        = u_ff;
      du_in       = du_ff;
      v_in        = v_ff;
      neg_in      = neg_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      p_in        = p_ff;
      steps_in    = steps_ff;
      reached_in  = reached_ff;
      inq_in      = inq_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_met_in  = rsp_met_ff;
      rsp_flow_in = rsp_flow_ff;
      rsp_cost_in = rsp_cost_ff;

      cap_we  = 1'b0; cap_wa  = '0; cap_wd  = '0; cap_ra  = '0;
      cost_we = 1'b0; cost_wa = '0; cost_wd = '0;
      cost_ra = (u_ff < vi) ? {u_ff, vi} : {vi, u_ff};
      dist_we = 1'b0; dist_wa = vi; dist_wd = nd; dist_ra = '0;
      par_we  = 1'b0; par_wa  = vi; par_wd  = u_ff; par_ra = cur_ff;
      q_we    = 1'b0; q_wa    = head_ff + count_ff[NODE_W-1:0]; q_wd = vi;
      q_ra    = head_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            cap_we = 1'b1;
            cap_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.edge_from != req_bus.edge_to) begin
                  cap_we  = 1'b1;
                  cap_wa  = {req_bus.edge_from, req_bus.edge_to};
                  cap_wd  = CAP_W'(req_bus.edge_capacity);
                  cost_we = 1'b1;
                  cost_wa = {e_lo, e_hi};
                  cost_wd = (req_bus.edge_from < req_bus.edge_to) ?
                            ECOST_W'(req_bus.edge_cost) : -ECOST_W'(req_bus.edge_cost);
               end
               if (req_bus.last_edge) state_in = ST_START;
            end
         end
         ST_START: begin
            if (cfg_n_ff < CNT_W'(2))              n_in = CNT_W'(2);
            else if (cfg_n_ff > CNT_W'(MAX_NODES)) n_in = CNT_W'(MAX_NODES);
            else                                   n_in = cfg_n_ff;
            flow_in  = '0;
            cost_in  = '0;
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            nn_in = POPS_W'(n_ff) * POPS_W'(n_ff);
            if (CNT_W'(cfg_s_ff) >= n_ff || CNT_W'(cfg_t_ff) >= n_ff) state_in = ST_DONE;
            else state_in = ST_LOOP;
         end
         ST_LOOP: begin
            state_in = (flow_ff < cfg_k_ff) ? ST_SEARCH : ST_DONE;
         end
         ST_SEARCH: begin
            dist_we    = 1'b1;
            dist_wa    = cfg_s_ff;
            dist_wd    = '0;
            q_we       = 1'b1;
            q_wa       = '0;
            q_wd       = cfg_s_ff;
            reached_in = '0;
            inq_in     = '0;
            reached_in[cfg_s_ff] = 1'b1;
            inq_in[cfg_s_ff]     = 1'b1;
            head_in    = '0;
            count_in   = CNT_W'(1);
            pops_in    = '0;
            state_in   = ST_POP;
         end
         ST_POP: begin
            if (count_ff == '0) begin
               if (reached_ff[cfg_t_ff]) begin
                  f_in     = cfg_k_ff - flow_ff;
                  cur_in   = cfg_t_ff;
                  steps_in = '0;
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (pops_ff >= nn_ff) begin
               state_in = ST_DONE;        // pop bound hit: negative cycle
            end else begin
               pops_in  = pops_ff + 1'b1;
               head_in  = head_ff + 1'b1;
               count_in = count_ff - 1'b1;
               state_in = ST_POP_NODE;
            end
         end
         ST_POP_NODE: begin
            u_in = q_rd_ff;
            inq_in[q_rd_ff] = 1'b0;
            dist_ra  = q_rd_ff;
            state_in = ST_POP_DIST;
         end
         ST_POP_DIST: begin
            du_in    = dist_rd_ff;
            v_in     = '0;
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (v_ff == n_ff) begin
               state_in = ST_POP;
            end else begin
               cap_ra   = {u_ff, vi};
               dist_ra  = vi;
               neg_in   = (u_ff > vi);
               state_in = ST_SCAN_EV;
            end
         end
         ST_SCAN_EV: begin
            if (cap_rd_ff != '0 && (!reached_ff[vi] || dist_rd_ff > nd)) begin
               dist_we = 1'b1;
               par_we  = 1'b1;
               reached_in[vi] = 1'b1;
               if (!inq_ff[vi] && count_ff < CNT_W'(MAX_NODES)) begin
                  inq_in[vi] = 1'b1;
                  q_we       = 1'b1;
                  count_in   = count_ff + 1'b1;
               end
            end
            v_in     = v_ff + 1'b1;
            state_in = ST_SCAN_RD;
         end
         // bottleneck walk from sink back to source
         ST_WALK: begin
            if (cur_ff == cfg_s_ff) begin
               state_in = (f_ff == '0) ? ST_DONE : ST_AUG;
               cur_in   = cfg_t_ff;
            end else begin
               state_in = ST_WALK_PAR;
            end
         end
         ST_WALK_PAR: begin
            p_in = par_rd_ff;
            if (steps_ff >= n_ff) begin
               state_in = ST_DONE;
            end else begin
               steps_in = steps_ff + 1'b1;
               cap_ra   = {par_rd_ff, cur_ff};
               state_in = ST_WALK_CAP;
            end
         end
         ST_WALK_CAP: begin
            if (cap_rd_ff < CAP_W'(f_ff)) f_in = cap_rd_ff[FLOW_W-1:0];
            cur_in   = p_ff;
            state_in = ST_WALK;
         end
         // push f along the path
         ST_AUG: begin
            state_in = (cur_ff == cfg_s_ff) ? ST_FIN_RD : ST_AUG_PAR;
         end
         ST_AUG_PAR: begin
            p_in     = par_rd_ff;
            cap_ra   = {par_rd_ff, cur_ff};
            state_in = ST_AUG_FWD;
         end
         ST_AUG_FWD: begin
            cap_we   = 1'b1;
            cap_wa   = {p_ff, cur_ff};
            cap_wd   = cap_rd_ff - CAP_W'(f_ff);
            cap_ra   = {cur_ff, p_ff};
            state_in = ST_AUG_BWD;
         end
         ST_AUG_BWD: begin
            cap_we   = 1'b1;
            cap_wa   = {cur_ff, p_ff};
            cap_wd   = cap_rd_ff + CAP_W'(f_ff);
            cur_in   = p_ff;
            state_in = ST_AUG;
         end
         ST_FIN_RD: begin
            dist_ra  = cfg_t_ff;
            state_in = ST_FIN_MUL;
         end
         ST_FIN_MUL: begin
            prod_in  = ACC_W'($signed({1'b0, f_ff}) * dist_rd_ff);
            flow_in  = flow_ff + f_ff;
            state_in = ST_FIN_ADD;
         end
         ST_FIN_ADD: begin
            if (acc_sum > (ACC_W+1)'(COST_MAX))      cost_in = COST_MAX;
            else if (acc_sum < (ACC_W+1)'(COST_MIN)) cost_in = COST_MIN;
            else                                      cost_in = acc_sum[ACC_W-1:0];
            state_in = ST_LOOP;
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_met_in   = (flow_ff >= cfg_k_ff);
               rsp_flow_in  = flow_ff;
               rsp_cost_in  = cost_ff;
               clr_in       = '0;
               state_in     = ST_CLEAR;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule
